// ===== hw/rtl/ssp_pkg.sv =====
// Shared types and constants for the SQL statement splitter.
package ssp_pkg;

	localparam int OFFSET_BITS_DEF = 16;
	localparam int OUT_BITS        = 16;
	localparam int QDEPTH          = 4;
	localparam int QPTR_BITS       = $clog2(QDEPTH);
	localparam int QCNT_BITS       = $clog2(QDEPTH + 1);

	localparam logic [7:0] TERM_RESET = 8'd59;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_NONE    = 8'h00;

	typedef enum logic [1:0] {
		SKIP_NORMAL,
		SKIP_LINE,
		SKIP_BLOCK,
		SKIP_CLOSING
	} skip_t;

	typedef enum logic [1:0] {
		QUOTE_NORMAL,
		QUOTE_STRING,
		QUOTE_IDENT
	} quote_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] start_ofs;
		logic [OUT_BITS-1:0] stop_ofs;
		logic                term;
	} result_t;

	// up to two results from one request, packed into slot r0 first
	typedef struct packed {
		result_t r0;
		result_t r1;
		logic    two;
	} rec_t;

endpackage

// ===== hw/rtl/ssp_front.sv =====
// Front end: byte lookahead, comment skipping and statement scanning.
module ssp_front #(
	parameter int OFFSET_BITS = ssp_pkg::OFFSET_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     text_byte,
	input  logic           end_of_text,
	input  logic [7:0]     term_char,
	input  logic           q_full,
	output logic           push,
	output ssp_pkg::rec_t  push_rec
);
	import ssp_pkg::*;

	localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;

	typedef struct packed {
		skip_t                  skip;
		logic                   scan;
		quote_t                 quote;
		logic [OFFSET_BITS-1:0] start;
	} st_t;

	typedef struct packed {
		st_t  st;
		logic hit;
	} pr_t;

	localparam st_t ST_RESET = '{skip: SKIP_NORMAL, scan: 1'b0, quote: QUOTE_NORMAL,
		start: '0};

	function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
		sat_inc = (v == OFS_MAX) ? v : v + 1'b1;
	endfunction

	function automatic pr_t process(input logic [7:0] b, input logic [7:0] la,
		input logic [OFFSET_BITS-1:0] ofs, input st_t st, input logic [7:0] tc);
		pr_t  r;
		logic go;
		r.st = st;
		r.hit = 1'b0;
		go = 1'b1;
		if (!st.scan) begin
			go = 1'b0;
			case (st.skip)
				SKIP_LINE: begin
					if (b == CH_LF) r.st.skip = SKIP_NORMAL;
				end
				SKIP_BLOCK: begin
					if (b == CH_STAR && la == CH_SLASH) r.st.skip = SKIP_CLOSING;
				end
				SKIP_CLOSING: begin
					r.st.skip = SKIP_NORMAL;
				end
				default: begin
					if (b == CH_DASH && la == CH_DASH) r.st.skip = SKIP_LINE;
					else if (b == CH_SLASH && la == CH_STAR) r.st.skip = SKIP_BLOCK;
					else if (!(b == CH_SPACE || b inside {[8'h09:8'h0D]})) begin
						go = 1'b1;
						r.st.scan = 1'b1;
						r.st.start = ofs;
						r.st.quote = QUOTE_NORMAL;
					end
				end
			endcase
		end
		if (go) begin
			case (r.st.quote)
				QUOTE_STRING: begin
					if (b == CH_SQUOTE) r.st.quote = QUOTE_NORMAL;
				end
				QUOTE_IDENT: begin
					if (b == CH_DQUOTE) r.st.quote = QUOTE_NORMAL;
				end
				default: begin
					if (b == tc) begin
						r.hit = 1'b1;
						r.st.scan = 1'b0;
						r.st.skip = SKIP_NORMAL;
						r.st.quote = QUOTE_NORMAL;
					end else if (b == CH_DQUOTE) begin
						r.st.quote = QUOTE_IDENT;
					end else if (b == CH_SQUOTE) begin
						r.st.quote = QUOTE_STRING;
					end
				end
			endcase
		end
		process = r;
	endfunction

	st_t                    st_q;
	logic [7:0]             held_byte_q;
	logic                   held_valid_q;
	logic [OFFSET_BITS-1:0] held_ofs_q;
	logic [OFFSET_BITS-1:0] pos_q;

	logic    accept;
	pr_t     p1, p2;
	logic    e1, e2, e3;
	result_t res1, res2, res3;

	assign in_stall = q_full;
	assign accept   = in_valid & ~in_stall;

	always_comb begin
		p1 = '{st: st_q, hit: 1'b0};
		if (held_valid_q) p1 = process(held_byte_q, text_byte, held_ofs_q, st_q, term_char);
		p2 = process(text_byte, CH_NONE, pos_q, p1.st, term_char);
		e1 = p1.hit;
		e2 = end_of_text & p2.hit;
		e3 = end_of_text & p2.st.scan;
		res1 = '{start_ofs: OUT_BITS'(p1.st.start), stop_ofs: OUT_BITS'(held_ofs_q),
			term: 1'b1};
		res2 = '{start_ofs: OUT_BITS'(p2.st.start), stop_ofs: OUT_BITS'(pos_q), term: 1'b1};
		res3 = '{start_ofs: OUT_BITS'(p2.st.start), stop_ofs: OUT_BITS'(sat_inc(pos_q)),
			term: 1'b0};
		push_rec.two = (e1 & (e2 | e3)) | (e2 & e3);
		if (e1) push_rec.r0 = res1;
		else if (e2) push_rec.r0 = res2;
		else push_rec.r0 = res3;
		if (e1 & e2) push_rec.r1 = res2;
		else push_rec.r1 = res3;
		push = accept & (e1 | e2 | e3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_RESET;
			held_valid_q <= 1'b0;
			held_byte_q  <= '0;
			held_ofs_q   <= '0;
			pos_q        <= '0;
		end else if (accept) begin
			if (end_of_text) begin
				st_q         <= ST_RESET;
				held_valid_q <= 1'b0;
				held_byte_q  <= '0;
				held_ofs_q   <= '0;
				pos_q        <= '0;
			end else begin
				st_q         <= p1.st;
				held_valid_q <= 1'b1;
				held_byte_q  <= text_byte;
				held_ofs_q   <= pos_q;
				pos_q        <= sat_inc(pos_q);
			end
		end
	end

endmodule

// ===== hw/rtl/ssp_queue.sv =====
// Result queue between the front end and the output side.
module ssp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ssp_pkg::rec_t push_rec,
	input  logic          pop,
	output logic          full,
	output logic          head_valid,
	output ssp_pkg::rec_t head_rec
);
	import ssp_pkg::*;

	rec_t                 mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0] cnt_q;
	logic                 do_pop;

	assign full       = (cnt_q == QCNT_BITS'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_rec   = mem_q[rd_ptr_q];
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push & ~do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop & ~push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== hw/rtl/ssp_back.sv =====
// Output side: delivers the one or two results of each queued record.
module ssp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  ssp_pkg::rec_t                 head_rec,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ssp_pkg::OUT_BITS-1:0]  stmt_start,
	output logic [ssp_pkg::OUT_BITS-1:0]  stmt_end,
	output logic                          terminated,
	output logic                          last_result
);
	import ssp_pkg::*;

	logic    slot_q;
	logic    fire;
	result_t cur;

	assign cur         = slot_q ? head_rec.r1 : head_rec.r0;
	assign out_valid   = head_valid;
	assign stmt_start  = cur.start_ofs;
	assign stmt_end    = cur.stop_ofs;
	assign terminated  = cur.term;
	assign last_result = slot_q | ~head_rec.two;
	assign fire        = out_valid & ~out_stall;
	assign pop         = fire & last_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= 1'b0;
		end else if (fire) begin
			slot_q <= ~last_result;
		end
	end

endmodule

// ===== hw/rtl/sql_statement_splitter.sv =====
// SQL statement splitter top level: config register, front end, queue, output side.
// A byte's result is pushed into the registered result queue once the request that
// supplies its lookahead is accepted (the next byte, or the same one with end_of_text set).
// Throughput: one byte per cycle unless in_stall; a two-result request yields two outputs.
// in_stall rises only when the four-entry result queue is full.
// Reset: asynchronous; scan state, offsets and queue clear, terminator returns to ';'.
module sql_statement_splitter #(
	parameter int OFFSET_BITS = ssp_pkg::OFFSET_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    text_byte,
	input  logic                          end_of_text,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ssp_pkg::OUT_BITS-1:0]  stmt_start,
	output logic [ssp_pkg::OUT_BITS-1:0]  stmt_end,
	output logic                          terminated,
	output logic                          last_result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [7:0]                    terminator_char
);
	import ssp_pkg::*;

	logic [7:0] term_q;
	logic       push, pop, full, head_valid;
	rec_t       push_rec, head_rec;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= TERM_RESET;
		end else if (cfg_valid & cfg_ready) begin
			term_q <= terminator_char;
		end
	end

	ssp_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.term_char  (term_q),
		.q_full     (full),
		.push       (push),
		.push_rec   (push_rec)
	);

	ssp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.pop       (pop),
		.full      (full),
		.head_valid(head_valid),
		.head_rec  (head_rec)
	);

	ssp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_rec   (head_rec),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.stmt_start (stmt_start),
		.stmt_end   (stmt_end),
		.terminated (terminated),
		.last_result(last_result)
	);

endmodule

// ===== hw/rtl/ssp_checker.sv =====
// Port-level checks for the SQL statement splitter, bound to the top level.
module ssp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [ssp_pkg::OUT_BITS-1:0] stmt_start,
	input logic [ssp_pkg::OUT_BITS-1:0] stmt_end,
	input logic                         terminated,
	input logic                         last_result
);

	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(stmt_start) && $stable(stmt_end)
			&& $stable(terminated) && $stable(last_result))
		else $error("output request changed while stalled");

	a_unterm_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !terminated |-> last_result)
		else $error("unterminated statement not marked last");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_result |=> out_valid)
		else $error("second result of a pair missing");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with nothing to deliver");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind sql_statement_splitter ssp_checker u_ssp_checker (.*);

// ===== dv/testbench.sv =====
// Testbench for the SQL statement splitter: byte-level statement predictor, directed and random scripts.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ssp_pkg::*;

	localparam logic [7:0] CH_HT = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;

	typedef struct packed {
		logic [OUT_BITS-1:0] start_ofs;
		logic [OUT_BITS-1:0] stop_ofs;
		logic                term;
		logic                is_last;
	} stmt_t;

	class stmt_tracker;
		logic [7:0]          term_char;
		skip_t               skip;
		quote_t              quote;
		bit                  scan;
		logic [7:0]          held;
		bit                  held_ok;
		logic [OUT_BITS-1:0] held_ofs;
		logic [OUT_BITS-1:0] pos;
		logic [OUT_BITS-1:0] start;
		stmt_t               expected_stmts[$];
		int                  n_new;
		int                  errors;

		function new();
			term_char = TERM_RESET;
			errors = 0;
			clear();
		endfunction

		function void clear();
			skip = SKIP_NORMAL;
			quote = QUOTE_NORMAL;
			scan = 1'b0;
			held = CH_NONE;
			held_ok = 1'b0;
			held_ofs = '0;
			pos = '0;
			start = '0;
		endfunction

		function logic [OUT_BITS-1:0] bump(logic [OUT_BITS-1:0] v);
			return (v == '1) ? v : v + 1'b1;
		endfunction

		function void emit(logic [OUT_BITS-1:0] s, logic [OUT_BITS-1:0] e, logic t);
			stmt_t r;
			r = {s, e, t, 1'b0};
			expected_stmts.push_back(r);
			n_new++;
		endfunction

		// one byte with its lookahead
		function void eat(logic [7:0] b, logic [7:0] la, logic [OUT_BITS-1:0] ofs);
			if (!scan) begin
				case (skip)
					SKIP_LINE: begin
						if (b == CH_LF) skip = SKIP_NORMAL;
						return;
					end
					SKIP_BLOCK: begin
						if (b == CH_STAR && la == CH_SLASH) skip = SKIP_CLOSING;
						return;
					end
					SKIP_CLOSING: begin
						skip = SKIP_NORMAL;
						return;
					end
					default: begin
						if (b == CH_DASH && la == CH_DASH) begin
							skip = SKIP_LINE;
							return;
						end
						if (b == CH_SLASH && la == CH_STAR) begin
							skip = SKIP_BLOCK;
							return;
						end
						if (b == CH_SPACE || (b >= CH_HT && b <= CH_CR)) return;
						scan = 1'b1;
						start = ofs;
						quote = QUOTE_NORMAL;
					end
				endcase
			end
			case (quote)
				QUOTE_STRING: begin
					if (b == CH_SQUOTE) quote = QUOTE_NORMAL;
				end
				QUOTE_IDENT: begin
					if (b == CH_DQUOTE) quote = QUOTE_NORMAL;
				end
				default: begin
					if (b == term_char) begin
						emit(start, ofs, 1'b1);
						scan = 1'b0;
						skip = SKIP_NORMAL;
						quote = QUOTE_NORMAL;
					end else if (b == CH_DQUOTE) begin
						quote = QUOTE_IDENT;
					end else if (b == CH_SQUOTE) begin
						quote = QUOTE_STRING;
					end
				end
			endcase
		endfunction

		function void take_byte(logic [7:0] b, logic eot);
			logic [OUT_BITS-1:0] ofs;
			ofs = pos;
			pos = bump(pos);
			n_new = 0;
			if (held_ok) eat(held, b, held_ofs);
			if (eot) begin
				eat(b, CH_NONE, ofs);
				if (scan) emit(start, bump(ofs), 1'b0);
				clear();
			end else begin
				held = b;
				held_ok = 1'b1;
				held_ofs = ofs;
			end
			if (n_new > 0) expected_stmts[expected_stmts.size() - 1].is_last = 1'b1;
		endfunction

		function void check_stmt(logic [OUT_BITS-1:0] s, logic [OUT_BITS-1:0] e, logic t,
				logic l);
			stmt_t got, want;
			got = {s, e, t, l};
			if (expected_stmts.size() == 0) begin
				$display("%0t: unexpected statement start=%0d end=%0d term=%0b last=%0b",
					$time, s, e, t, l);
				errors++;
				return;
			end
			want = expected_stmts.pop_front();
			if (got !== want) begin
				$display("%0t: mismatch expected start=%0d end=%0d term=%0b last=%0b,",
					$time, want.start_ofs, want.stop_ofs, want.term, want.is_last,
					" actual start=%0d end=%0d term=%0b last=%0b", s, e, t, l);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [7:0]          text_byte;
	logic                end_of_text;
	logic                out_valid;
	logic                out_stall;
	logic [OUT_BITS-1:0] stmt_start;
	logic [OUT_BITS-1:0] stmt_end;
	logic                terminated;
	logic                last_result;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [7:0]          terminator_char;

	stmt_tracker tracker = new();
	logic [7:0]  script_q[$];
	int          send_idle_pct;
	int          recv_idle_pct;
	int          stall_hold;

	sql_statement_splitter u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.text_byte      (text_byte),
		.end_of_text    (end_of_text),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.stmt_start     (stmt_start),
		.stmt_end       (stmt_end),
		.terminated     (terminated),
		.last_result    (last_result),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.terminator_char(terminator_char)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_req(input logic [7:0] b, input logic eot);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		end_of_text <= eot;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracker.take_byte(b, eot);
	endtask

	task automatic send_script();
		for (int i = 0; i < script_q.size(); i++)
			send_req(script_q[i], i == script_q.size() - 1);
		script_q.delete();
	endtask

	function automatic void push_byte(logic [7:0] b);
		script_q.push_back(b);
	endfunction

	function automatic void push_str(string s);
		for (int i = 0; i < s.len(); i++) script_q.push_back(s[i]);
	endfunction

	function automatic logic [7:0] pick_any(string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	// register write only once the block has drained
	task automatic write_term(input logic [7:0] v);
		in_valid <= 1'b0;
		while (tracker.expected_stmts.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		terminator_char <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		tracker.term_char = v;
	endtask

	task automatic run_phase(input logic [7:0] term_val, input int s_pct, input int r_pct,
			input int target_bytes);
		int          sent;
		int unsigned k;
		logic [7:0]  tc;
		write_term(term_val);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		sent = 0;
		tc = tracker.term_char;
		while (sent < target_bytes) begin
			repeat ($urandom_range(1, 12)) begin
				case ($urandom_range(0, 9))
					0: begin
						repeat ($urandom_range(1, 3)) begin
							k = $urandom_range(0, 5);
							push_byte(k == 5 ? CH_SPACE : CH_HT + k[7:0]);
						end
					end
					1: begin
						push_str("--");
						repeat ($urandom_range(0, 5))
							push_byte(8'($urandom_range(8'h20, 8'h7E)));
						if ($urandom_range(0, 3) != 0) push_byte(CH_LF);
					end
					2: begin
						push_str("/*");
						repeat ($urandom_range(0, 4)) push_byte(pick_any("a*/ -"));
						if ($urandom_range(0, 3) != 0) push_str("*/");
					end
					3, 4: begin
						k = $urandom_range(0, 1);
						push_byte(k ? CH_DQUOTE : CH_SQUOTE);
						repeat ($urandom_range(0, 4)) begin
							if ($urandom_range(0, 3) == 0 && tc != CH_NONE) push_byte(tc);
							else push_byte(pick_any("ab'\" ;"));
						end
						if ($urandom_range(0, 5) != 0) push_byte(k ? CH_DQUOTE : CH_SQUOTE);
					end
					5, 6: begin
						repeat ($urandom_range(1, 5))
							push_byte(8'($urandom_range(8'h61, 8'h7A)));
					end
					7: begin
						if (tc != CH_NONE) push_byte(tc);
						else push_byte(8'($urandom_range(1, 255)));
					end
					8: push_byte(8'($urandom_range(1, 255)));
					default: push_byte(pick_any("-/*"));
				endcase
			end
			sent += script_q.size();
			send_script();
		end
	endtask

	// output side: random stall plus a long hold-off on request
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				tracker.check_stmt(stmt_start, stmt_end, terminated, last_result);
			if (stall_hold > 0) begin
				out_stall <= 1'b1;
				stall_hold--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	initial begin
		#10_000_000;
		$display("FAIL sql_statement_splitter");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		text_byte = CH_NONE;
		end_of_text = 1'b0;
		cfg_valid = 1'b0;
		terminator_char = TERM_RESET;
		send_idle_pct = 15;
		recv_idle_pct = 63;
		stall_hold = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed scripts with the reset terminator
		push_str("/**//*/x;");
		send_script();
		push_str(";;");
		send_script();
		push_str("--\n'a;'\"b;\"");
		push_byte(8'h01);
		push_byte(8'hFF);
		send_script();
		push_str(" ");
		send_script();
		push_str("a");
		send_script();

		run_phase(8'hFF, 15, 63, 230);
		run_phase(8'h00, 15, 63, 230);
		run_phase(CH_SQUOTE, 63, 15, 230);
		run_phase(CH_SPACE, 63, 15, 230);
		in_valid <= 1'b0;
		while (tracker.expected_stmts.size() != 0) @(posedge clk);
		stall_hold = 300;
		run_phase(8'($urandom_range(0, 255)), 0, 0, 230);
		run_phase(TERM_RESET, 0, 0, 230);

		in_valid <= 1'b0;
		while (tracker.expected_stmts.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.errors == 0 && tracker.expected_stmts.size() == 0) begin
			$display("PASS sql_statement_splitter");
		end else begin
			$display("FAIL sql_statement_splitter");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/ssp_pkg.sv
hw/rtl/ssp_front.sv
hw/rtl/ssp_queue.sv
hw/rtl/ssp_back.sv
hw/rtl/sql_statement_splitter.sv
hw/rtl/ssp_checker.sv
dv/testbench.sv
